>>> rtl/core/rsfc_pkg.sv
`timescale 1ns / 1ps

package rsfc_pkg;

    localparam int PAYLOAD_DEPTH = 64;
    localparam int PCOUNT_W      = $clog2(PAYLOAD_DEPTH + 1);
    localparam int INDEX_W       = 6;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCOUNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;

    localparam logic [23:0] SENTENCE_TYPE_RESET = 24'h524D43;

    localparam logic [2:0] HDR_FIRST  = 3'd3;
    localparam logic [2:0] HDR_SECOND = 3'd4;
    localparam logic [2:0] HDR_LAST   = 3'd5;

    typedef enum logic [1:0] {
        ST_PENDING  = 2'd0,
        ST_MATCH    = 2'd1,
        ST_MISMATCH = 2'd2
    } status_t;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_HEADER  = 7'b0000010,
        PH_SKIP    = 7'b0000100,
        PH_PAYLOAD = 7'b0001000,
        PH_CKHI    = 7'b0010000,
        PH_CKLO    = 7'b0100000,
        PH_IGNORE  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       is_dollar;
        logic       is_star;
        logic       is_mark;
        logic       hex_ok;
        logic [3:0] hex_val;
    } word_t;

endpackage

>>> rtl/core/rmc_sentence_filter_checksum.sv
`timescale 1ns / 1ps

// sentence filter with checksum check, one received character per word
// input channel: in_valid / in_stall carry rx_byte; output channel:
//   out_valid / out_stall carry status, payload_valid, payload_byte,
//   payload_index and overflow, exactly one output word per input word
// config: cfg_wr_en writes cfg_wr_data as the three-character sentence type
//   (first character in bits 23:16); the user must write it only while no
//   words are in flight, which the block itself does not enforce
// throughput: one word per cycle while out_stall is low; the front classifies
//   characters into a two-entry queue and the back runs the sentence state
//   machine on one queued word per cycle into an output register
// receiver stall: the output register holds, the back stops draining the
//   queue, and in_stall rises once the queue is full; no word is lost
// reset: queue and output register empty, state machine idle, sentence
//   type returns to "RMC"
module rmc_sentence_filter_checksum (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [7:0]                   rx_byte,
    input  logic                         cfg_wr_en,
    input  logic [23:0]                  cfg_wr_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [1:0]                   status,
    output logic                         payload_valid,
    output logic [7:0]                   payload_byte,
    output logic [rsfc_pkg::INDEX_W-1:0] payload_index,
    output logic                         overflow
);
    import rsfc_pkg::*;

    logic  q_valid;
    logic  pop;
    word_t q_word;

    rsfc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_word   (q_word)
    );

    rsfc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_valid       (q_valid),
        .q_word        (q_word),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .payload_valid (payload_valid),
        .payload_byte  (payload_byte),
        .payload_index (payload_index),
        .overflow      (overflow)
    );

endmodule

>>> rtl/core/rsfc_front.sv
`timescale 1ns / 1ps

module rsfc_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [7:0]    rx_byte,
    input  logic          pop,
    output logic          q_valid,
    output rsfc_pkg::word_t q_word
);
    import rsfc_pkg::*;

    word_t                cls;
    word_t                q_mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]    wr_ptr_reg;
    logic [QPTR_W-1:0]    wr_ptr_next;
    logic [QPTR_W-1:0]    rd_ptr_reg;
    logic [QPTR_W-1:0]    rd_ptr_next;
    logic [QCOUNT_W-1:0]  count_reg;
    logic [QCOUNT_W-1:0]  count_next;
    logic                 push;
    logic                 do_pop;

    // character classification
    always_comb
    begin
        cls.data      = rx_byte;
        cls.is_dollar = (rx_byte == CHAR_DOLLAR);
        cls.is_star   = (rx_byte == CHAR_STAR);
        cls.is_mark   = (rx_byte == CHAR_A);
        cls.hex_ok    = 1'b0;
        cls.hex_val   = 4'd0;
        if (rx_byte inside {[8'h30:8'h39]})
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = 4'(rx_byte - CHAR_ZERO);
        end
        else if (rx_byte inside {[8'h41:8'h46]})
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = 4'(rx_byte - 8'h37);
        end
        else if (rx_byte inside {[8'h61:8'h66]})
        begin
            cls.hex_ok  = 1'b1;
            cls.hex_val = 4'(rx_byte - 8'h57);
        end
    end

    assign in_stall = (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign do_pop   = pop && q_valid;
    assign q_word   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

>>> rtl/core/rsfc_back.sv
`timescale 1ns / 1ps

module rsfc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [23:0]                 cfg_wr_data,
    input  logic                        q_valid,
    input  rsfc_pkg::word_t             q_word,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  status,
    output logic                        payload_valid,
    output logic [7:0]                  payload_byte,
    output logic [rsfc_pkg::INDEX_W-1:0] payload_index,
    output logic                        overflow
);
    import rsfc_pkg::*;

    logic [23:0]         stype_reg;
    phase_t              phase_reg,   phase_next;
    logic [2:0]          hcount_reg,  hcount_next;
    logic                tmatch_reg,  tmatch_next;
    logic [7:0]          xor_reg,     xor_next;
    logic [PCOUNT_W-1:0] pcount_reg,  pcount_next;
    logic                ovf_reg,     ovf_next;
    logic [3:0]          ckhi_reg,    ckhi_next;

    logic                out_valid_reg;
    status_t             status_reg,  status_next;
    logic                pvalid_reg,  pvalid_next;
    logic [7:0]          pbyte_reg,   pbyte_next;
    logic [INDEX_W-1:0]  pindex_reg,  pindex_next;
    logic                ovf_out_reg;

    logic                advance;
    logic [7:0]          want;

    assign advance = !out_valid_reg || !out_stall;
    assign pop     = advance && q_valid;

    always_comb
    begin
        phase_next  = phase_reg;
        hcount_next = hcount_reg;
        tmatch_next = tmatch_reg;
        xor_next    = xor_reg;
        pcount_next = pcount_reg;
        ovf_next    = ovf_reg;
        ckhi_next   = ckhi_reg;
        status_next = ST_PENDING;
        pvalid_next = 1'b0;
        pbyte_next  = 8'd0;
        pindex_next = '0;
        want        = 8'd0;

        if (q_word.is_dollar)
        begin
            phase_next  = PH_HEADER;
            hcount_next = 3'd0;
            tmatch_next = 1'b1;
            xor_next    = 8'd0;
            pcount_next = '0;
            ovf_next    = 1'b0;
            ckhi_next   = 4'd0;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (q_word.is_star)
                    begin
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        xor_next    = xor_reg ^ q_word.data;
                        hcount_next = hcount_reg + 3'd1;
                        case (hcount_next)
                            HDR_FIRST:  want = stype_reg[23:16];
                            HDR_SECOND: want = stype_reg[15:8];
                            default:    want = stype_reg[7:0];
                        endcase
                        if (hcount_next inside {[HDR_FIRST:HDR_LAST]})
                        begin
                            if (want != q_word.data)
                            begin
                                tmatch_next = 1'b0;
                            end
                            if (hcount_next == HDR_LAST)
                            begin
                                phase_next = tmatch_next ? PH_SKIP : PH_IGNORE;
                            end
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (q_word.is_star)
                    begin
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ q_word.data;
                        if (q_word.is_mark)
                        begin
                            phase_next  = PH_PAYLOAD;
                            pcount_next = '0;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (pcount_reg < PCOUNT_W'(PAYLOAD_DEPTH))
                    begin
                        pvalid_next = 1'b1;
                        pbyte_next  = q_word.data;
                        pindex_next = pcount_reg[INDEX_W-1:0];
                        pcount_next = pcount_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (q_word.is_star)
                    begin
                        phase_next = PH_CKHI;
                    end
                    else
                    begin
                        xor_next = xor_reg ^ q_word.data;
                    end
                end
                PH_CKHI:
                begin
                    if (!q_word.hex_ok)
                    begin
                        status_next = ST_MISMATCH;
                        phase_next  = PH_IDLE;
                    end
                    else
                    begin
                        ckhi_next  = q_word.hex_val;
                        phase_next = PH_CKLO;
                    end
                end
                PH_CKLO:
                begin
                    if (q_word.hex_ok && ({ckhi_reg, q_word.hex_val} == xor_reg))
                    begin
                        status_next = ST_MATCH;
                    end
                    else
                    begin
                        status_next = ST_MISMATCH;
                    end
                    phase_next = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stype_reg     <= SENTENCE_TYPE_RESET;
            phase_reg     <= PH_IDLE;
            hcount_reg    <= 3'd0;
            tmatch_reg    <= 1'b1;
            xor_reg       <= 8'd0;
            pcount_reg    <= '0;
            ovf_reg       <= 1'b0;
            ckhi_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                stype_reg <= cfg_wr_data;
            end
            if (pop)
            begin
                phase_reg  <= phase_next;
                hcount_reg <= hcount_next;
                tmatch_reg <= tmatch_next;
                xor_reg    <= xor_next;
                pcount_reg <= pcount_next;
                ovf_reg    <= ovf_next;
                ckhi_reg   <= ckhi_next;
            end
            if (advance)
            begin
                out_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            status_reg  <= status_next;
            pvalid_reg  <= pvalid_next;
            pbyte_reg   <= pbyte_next;
            pindex_reg  <= pindex_next;
            ovf_out_reg <= ovf_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign payload_valid = pvalid_reg;
    assign payload_byte  = pbyte_reg;
    assign payload_index = pindex_reg;
    assign overflow      = ovf_out_reg;

endmodule

>>> rtl/core/rsfc_checker.sv
`timescale 1ns / 1ps

module rsfc_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [1:0]                   status,
    input  logic                         payload_valid,
    input  logic [7:0]                   payload_byte,
    input  logic [rsfc_pkg::INDEX_W-1:0] payload_index,
    input  logic                         overflow
);
    import rsfc_pkg::*;

    // held word stays put while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status)
            && $stable(payload_valid) && $stable(payload_byte)
            && $stable(payload_index) && $stable(overflow))
        else $error("output word changed under stall");

    a_payload_no_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> status == ST_PENDING)
        else $error("payload word carries a verdict");

    a_empty_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !payload_valid |-> payload_byte == 8'd0 && payload_index == '0)
        else $error("non-payload word has payload bits");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_PENDING || status == ST_MATCH || status == ST_MISMATCH)
        else $error("undefined status code");

    a_no_start_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && payload_valid |-> payload_byte != CHAR_DOLLAR)
        else $error("start mark streamed as payload");

endmodule

bind rmc_sentence_filter_checksum rsfc_checker u_rsfc_checker (.*);
